FILE: rtl/core/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the turntable photo autostop block.
// ----------------------------------------------------------------------------
package tpa_pkg;

	// sample and field widths
	localparam int SAMPLE_BITS = 10;
	localparam int TIME_BITS   = 32;
	localparam int GAP_BITS    = 16;
	localparam int CAUSE_BITS  = 2;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// largest sample, also the reset of the previous average
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	// register reset values
	localparam logic [SAMPLE_BITS-1:0] LEVEL_LIMIT_RST    = SAMPLE_BITS'(1023);
	localparam logic [SAMPLE_BITS-1:0] RISE_THRESHOLD_RST = SAMPLE_BITS'(32);
	localparam logic [GAP_BITS-1:0]    SESSION_GAP_RST    = GAP_BITS'(200);

	// register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LEVEL_LIMIT    = 2'd0,
		REG_RISE_THRESHOLD = 2'd1,
		REG_SESSION_GAP    = 2'd2
	} tpa_reg_idx_t;

	// stop cause codes
	typedef enum logic [CAUSE_BITS-1:0] {
		CAUSE_NONE  = 2'd0,
		CAUSE_LEVEL = 2'd1,
		CAUSE_RISE  = 2'd2
	} tpa_cause_t;

	// one input word
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] photo_sample;
		logic [TIME_BITS-1:0]   now_ms;
		logic                   motor_on;
	} tpa_sample_t;

	// one result word
	typedef struct packed {
		logic                   stop_motor;
		logic [CAUSE_BITS-1:0]  stop_cause;
		logic                   session_done;
		logic [SAMPLE_BITS-1:0] session_average;
	} tpa_result_t;

endpackage

FILE: rtl/core/tpa_in_if.sv
// ----------------------------------------------------------------------------
// tpa_in_if
// Sample channel: valid/ready handshake with one photo sample word.
// ----------------------------------------------------------------------------
interface tpa_in_if;
	import tpa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] photo_sample;
	logic [TIME_BITS-1:0]   now_ms;
	logic                   motor_on;

	modport source (output valid, output photo_sample, output now_ms, output motor_on,
		input ready);
	modport sink (input valid, input photo_sample, input now_ms, input motor_on,
		output ready);
endinterface

FILE: rtl/core/tpa_out_if.sv
// ----------------------------------------------------------------------------
// tpa_out_if
// Result channel: valid/ready handshake with one autostop result word.
// ----------------------------------------------------------------------------
interface tpa_out_if;
	import tpa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   stop_motor;
	logic [CAUSE_BITS-1:0]  stop_cause;
	logic                   session_done;
	logic [SAMPLE_BITS-1:0] session_average;

	modport source (output valid, output stop_motor, output stop_cause,
		output session_done, output session_average, input ready);
	modport sink (input valid, input stop_motor, input stop_cause,
		input session_done, input session_average, output ready);
endinterface

FILE: rtl/core/tpa_cfg_if.sv
// ----------------------------------------------------------------------------
// tpa_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
interface tpa_cfg_if;
	import tpa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/turntable_photo_autostop_top.sv
// ----------------------------------------------------------------------------
// turntable_photo_autostop_top
// Photo sensor autostop: level stop and rising session average stop.
// ----------------------------------------------------------------------------
// One result word comes out for every sample word taken in, one word per
// clock sustained while the result port is ready. A word sits in the input
// register, where the level check, the session accumulate and the average
// compare run against the session state, and is then held in the result
// register until taken; result valid rises when the word moves from the input
// register into the result register. The session state is updated in the
// same cycle the result is registered, so the next sample sees it right
// away. Configuration writes are always accepted and should be made only
// while no samples are in flight.
module turntable_photo_autostop_top #(
	parameter int SAMPLES_LOG2 = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	tpa_in_if.sink     samples,
	tpa_out_if.source  results,
	tpa_cfg_if.sink    cfg
);
	import tpa_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + SAMPLES_LOG2;
	localparam int CNT_BITS = SAMPLES_LOG2 + 1;
	localparam logic [CNT_BITS-1:0] SESSION_LEN = CNT_BITS'(1) << SAMPLES_LOG2;

	// configuration registers
	logic [SAMPLE_BITS-1:0] level_limit_q;
	logic [SAMPLE_BITS-1:0] rise_threshold_q;
	logic [GAP_BITS-1:0]    session_gap_q;

	// session state
	logic [SUM_BITS-1:0]    sample_sum_q;
	logic [CNT_BITS-1:0]    sample_count_q;
	logic [SAMPLE_BITS-1:0] previous_average_q;
	logic [TIME_BITS-1:0]   session_start_q;

	// pipeline registers
	logic        valid_s1;
	tpa_sample_t word_s1;
	logic        valid_s2;
	tpa_result_t result_s2;

	// handshake
	logic advance;
	logic take;

	// compute signals
	logic [TIME_BITS-1:0]   elapsed;
	logic                   level_hit;
	logic                   gap_open;
	logic [SUM_BITS-1:0]    sum_next;
	logic [CNT_BITS-1:0]    count_next;
	logic                   session_end;
	logic [SAMPLE_BITS-1:0] average;
	logic                   rise_hit;
	tpa_result_t            result_d;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_limit_q    <= LEVEL_LIMIT_RST;
			rise_threshold_q <= RISE_THRESHOLD_RST;
			session_gap_q    <= SESSION_GAP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEVEL_LIMIT:    level_limit_q    <= cfg.data[SAMPLE_BITS-1:0];
				REG_RISE_THRESHOLD: rise_threshold_q <= cfg.data[SAMPLE_BITS-1:0];
				REG_SESSION_GAP:    session_gap_q    <= cfg.data[GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// flow control: result register frees when empty or taken
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign take          = samples.valid && samples.ready;
	assign samples.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.photo_sample <= samples.photo_sample;
			word_s1.now_ms       <= samples.now_ms;
			word_s1.motor_on     <= samples.motor_on;
		end
	end

	// level check, gap check, accumulate and average compare
	always_comb begin
		elapsed     = word_s1.now_ms - session_start_q;
		level_hit   = word_s1.photo_sample > level_limit_q;
		gap_open    = elapsed > TIME_BITS'(session_gap_q);
		sum_next    = sample_sum_q + SUM_BITS'(word_s1.photo_sample);
		count_next  = sample_count_q + CNT_BITS'(1);
		session_end = count_next >= SESSION_LEN;
		average     = SAMPLE_BITS'(sum_next >> SAMPLES_LOG2);
		rise_hit    = ({1'b0, previous_average_q} + {1'b0, rise_threshold_q})
			< {1'b0, average};

		result_d.stop_motor      = 1'b0;
		result_d.stop_cause      = CAUSE_NONE;
		result_d.session_done    = 1'b0;
		result_d.session_average = '0;
		if (word_s1.motor_on) begin
			if (level_hit) begin
				result_d.stop_motor = 1'b1;
				result_d.stop_cause = CAUSE_LEVEL;
			end else if (gap_open && session_end) begin
				result_d.session_done    = 1'b1;
				result_d.session_average = average;
				if (rise_hit) begin
					result_d.stop_motor = 1'b1;
					result_d.stop_cause = CAUSE_RISE;
				end
			end
		end
	end

	// session state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q       <= '0;
			sample_count_q     <= '0;
			previous_average_q <= SAMPLE_MAX;
			session_start_q    <= '0;
		end else if (advance && word_s1.motor_on && !level_hit && gap_open) begin
			if (session_end) begin
				sample_sum_q       <= '0;
				sample_count_q     <= '0;
				previous_average_q <= average;
				session_start_q    <= word_s1.now_ms;
			end else begin
				sample_sum_q   <= sum_next;
				sample_count_q <= count_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || results.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign results.valid           = valid_s2;
	assign results.stop_motor      = result_s2.stop_motor;
	assign results.stop_cause      = result_s2.stop_cause;
	assign results.session_done    = result_s2.session_done;
	assign results.session_average = result_s2.session_average;

endmodule
